// ===== rtl/hjd_pkg.sv =====
package hjd_pkg;

    // Configuration register widths.
    localparam int TICKS_W   = 16;
    localparam int REPEATS_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Timer width default.
    localparam int TIMER_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_DEBOUNCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_SETTLE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_REPEATS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TV_OUT          = 3'd5;

    // Configuration reset values.
    localparam logic [TICKS_W-1:0]   DETECT_DEBOUNCE_RST = 16'd300;
    localparam logic [TICKS_W-1:0]   HOLD_RST            = 16'd3000;
    localparam logic [TICKS_W-1:0]   BUTTON_DEBOUNCE_RST = 16'd100;
    localparam logic [TICKS_W-1:0]   BIAS_SETTLE_RST     = 16'd50;
    localparam logic [REPEATS_W-1:0] BUTTON_REPEATS_RST  = 8'd20;

    // Sequencer phase codes.
    localparam logic [2:0] PH_IDLE           = 3'd0;
    localparam logic [2:0] PH_DEBOUNCE       = 3'd1;
    localparam logic [2:0] PH_SETTLE_PLUG    = 3'd2;
    localparam logic [2:0] PH_SETTLE_RECHECK = 3'd3;
    localparam logic [2:0] PH_HOLD           = 3'd4;
    localparam logic [2:0] PH_SETTLE_RETEST  = 3'd5;

    // State code values that get remapped in the alternate code.
    localparam logic [2:0] CODE_PLUG_ONLY = 3'd1;
    localparam logic [2:0] CODE_PLUG_MIC  = 3'd3;
    localparam logic [2:0] ALT_PLUG_ONLY  = 3'd2;
    localparam logic [2:0] ALT_PLUG_MIC   = 3'd1;

endpackage

// ===== rtl/headset_jack_detector.sv =====
// Channel   Direction  Payload (low bit first)
// s_axis    in         detect_pin, send_end_a, send_end_b
// m_axis    out        state_code, alt_code, code_changed, button_down,
//                      button_event, mic_bias_on
// cfg       in         index selects one of six registers, write only
//
// One item per cycle sustained while the output is not stalled. An item is held in
// the input register; when it fires, the sequencer and button logic update state and
// the result register loads in the same cycle. Reset clears the valid flags, resets
// the sequencer state and loads the register defaults; the data registers are not reset.
// A stalled output holds the result register; the input register still takes one more item.
module headset_jack_detector
    import hjd_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // cfg: write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    // s_axis_tdata: [0] detect_pin, [1] send_end_a, [2] send_end_b, [7:3] zero
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,
    // m_axis_tdata: [2:0] state_code, [5:3] alt_code, [6] code_changed,
    // [7] button_down, [8] button_event, [9] mic_bias_on, [15:10] zero
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata
);

    localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

    // Timer load: zero acts as one, values beyond the timer width saturate.
    function automatic logic [TIMER_BITS-1:0] load_len(input logic [TICKS_W-1:0] v);
        logic [32:0] x;
        x = 33'(v);
        if (x > TMAX)
        begin
            x = TMAX;
        end
        if (x == 33'd0)
        begin
            x = 33'd1;
        end
        return TIMER_BITS'(x);
    endfunction

    // Configuration registers.
    logic [TICKS_W-1:0]   detect_debounce_reg;
    logic [TICKS_W-1:0]   hold_reg;
    logic [TICKS_W-1:0]   button_debounce_reg;
    logic [TICKS_W-1:0]   bias_settle_reg;
    logic [REPEATS_W-1:0] button_repeats_reg;
    logic                 tv_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_debounce_reg <= DETECT_DEBOUNCE_RST;
            hold_reg            <= HOLD_RST;
            button_debounce_reg <= BUTTON_DEBOUNCE_RST;
            bias_settle_reg     <= BIAS_SETTLE_RST;
            button_repeats_reg  <= BUTTON_REPEATS_RST;
            tv_out_reg          <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DETECT_DEBOUNCE: detect_debounce_reg <= cfg_data;
                REG_HOLD:            hold_reg            <= cfg_data;
                REG_BUTTON_DEBOUNCE: button_debounce_reg <= cfg_data;
                REG_BIAS_SETTLE:     bias_settle_reg     <= cfg_data;
                REG_BUTTON_REPEATS:  button_repeats_reg  <= cfg_data[REPEATS_W-1:0];
                REG_TV_OUT:          tv_out_reg          <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Input register and handshake.
    logic       in_valid_reg;
    logic [2:0] in_pins_reg;
    logic       out_valid_reg;
    logic [9:0] out_data_reg;
    logic       fire;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_pins_reg <= s_axis_tdata[2:0];
        end
    end

    // Block state.
    logic [2:0]            phase_reg, phase_next;
    logic [TIMER_BITS-1:0] main_timer_reg, main_timer_next;
    logic [TIMER_BITS-1:0] button_timer_reg, button_timer_next;
    logic                  plugged_reg, plugged_next;
    logic                  mic_found_reg, mic_found_next;
    logic                  in_hold_reg, in_hold_next;
    logic                  button_testing_reg, button_testing_next;
    logic                  button_level_reg, button_level_next;
    logic                  button_running_reg, button_running_next;
    logic                  bias_level_reg, bias_level_next;
    logic [REPEATS_W-1:0]  press_count_reg, press_count_next;
    logic [REPEATS_W-1:0]  release_count_reg, release_count_next;
    logic [2:0]            prev_pins_reg, prev_pins_next;
    logic [9:0]            result;

    // One tick of the sequencer and button debounce.
    always_comb
    begin
        logic       det, sa, sb, found, reported, bevent, done, lvl;
        logic [2:0] ph, code, alt;

        det = in_pins_reg[0];
        sa  = in_pins_reg[1];
        sb  = in_pins_reg[2];
        found    = sa && !sb;
        reported = 1'b0;
        bevent   = 1'b0;
        done     = 1'b0;
        lvl      = 1'b0;
        ph       = phase_reg;

        phase_next          = phase_reg;
        main_timer_next     = main_timer_reg;
        button_timer_next   = button_timer_reg;
        plugged_next        = plugged_reg;
        mic_found_next      = mic_found_reg;
        in_hold_next        = in_hold_reg;
        button_testing_next = button_testing_reg;
        button_level_next   = button_level_reg;
        button_running_next = button_running_reg;
        bias_level_next     = bias_level_reg;
        press_count_next    = press_count_reg;
        release_count_next  = release_count_reg;
        prev_pins_next      = prev_pins_reg;

        // Button check timer expiry.
        if (button_running_reg)
        begin
            if (button_timer_reg <= TIMER_BITS'(1))
            begin
                button_timer_next   = '0;
                button_running_next = 1'b0;
                if (det)
                begin
                    button_testing_next = 1'b0;
                    press_count_next    = '0;
                    release_count_next  = '0;
                end
                else if (sa == sb)
                begin
                    if (press_count_reg < button_repeats_reg)
                    begin
                        release_count_next  = '0;
                        press_count_next    = press_count_reg + REPEATS_W'(1);
                        button_timer_next   = load_len(button_debounce_reg);
                        button_running_next = 1'b1;
                    end
                    else
                    begin
                        done = 1'b1;
                        lvl  = 1'b1;
                    end
                end
                else
                begin
                    press_count_next = '0;
                    if (release_count_reg < button_repeats_reg)
                    begin
                        release_count_next  = release_count_reg + REPEATS_W'(1);
                        button_timer_next   = load_len(button_debounce_reg);
                        button_running_next = 1'b1;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                if (done)
                begin
                    if (button_level_reg != lvl)
                    begin
                        button_level_next = lvl;
                        bevent            = 1'b1;
                    end
                    press_count_next    = '0;
                    release_count_next  = '0;
                    button_testing_next = 1'b1;
                end
            end
            else
            begin
                button_timer_next = button_timer_reg - TIMER_BITS'(1);
            end
        end

        // Detect, settle and hold sequencer.
        if (phase_reg != PH_IDLE)
        begin
            if (main_timer_reg <= TIMER_BITS'(1))
            begin
                main_timer_next = '0;
                phase_next      = PH_IDLE;
                unique case (ph)
                    PH_DEBOUNCE:
                    begin
                        in_hold_next        = 1'b1;
                        button_testing_next = 1'b0;
                        if (!det != plugged_reg)
                        begin
                            plugged_next = !det;
                            if (!det)
                            begin
                                bias_level_next = 1'b1;
                                phase_next      = PH_SETTLE_PLUG;
                                main_timer_next = load_len(bias_settle_reg);
                            end
                            else
                            begin
                                bias_level_next = 1'b0;
                                mic_found_next  = 1'b0;
                                reported        = 1'b1;
                            end
                        end
                        else if (plugged_reg && mic_found_reg)
                        begin
                            bias_level_next = 1'b1;
                            phase_next      = PH_SETTLE_RECHECK;
                            main_timer_next = load_len(bias_settle_reg);
                        end
                        if (phase_next == PH_IDLE)
                        begin
                            phase_next      = PH_HOLD;
                            main_timer_next = load_len(hold_reg);
                        end
                    end
                    PH_SETTLE_PLUG, PH_SETTLE_RECHECK:
                    begin
                        if (!found)
                        begin
                            bias_level_next = 1'b0;
                        end
                        if (ph == PH_SETTLE_PLUG || mic_found_reg != found)
                        begin
                            mic_found_next = found;
                            reported       = 1'b1;
                        end
                        phase_next      = PH_HOLD;
                        main_timer_next = load_len(hold_reg);
                    end
                    PH_HOLD:
                    begin
                        if (!mic_found_reg)
                        begin
                            bias_level_next = 1'b1;
                            phase_next      = PH_SETTLE_RETEST;
                            main_timer_next = load_len(bias_settle_reg);
                        end
                        else
                        begin
                            button_testing_next = 1'b1;
                        end
                    end
                    PH_SETTLE_RETEST:
                    begin
                        if (!found)
                        begin
                            bias_level_next = 1'b0;
                        end
                        if (!mic_found_reg && found)
                        begin
                            mic_found_next = 1'b1;
                            reported       = 1'b1;
                        end
                        if (mic_found_next)
                        begin
                            button_testing_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            else
            begin
                main_timer_next = main_timer_reg - TIMER_BITS'(1);
            end
        end

        // Pin edges, held back while a settle wait runs.
        if (!(phase_next == PH_SETTLE_PLUG || phase_next == PH_SETTLE_RECHECK ||
              phase_next == PH_SETTLE_RETEST))
        begin
            if (in_pins_reg[0] != prev_pins_reg[0])
            begin
                button_testing_next = 1'b0;
                in_hold_next        = 1'b0;
                phase_next          = PH_DEBOUNCE;
                main_timer_next     = load_len(detect_debounce_reg);
            end
            if ((in_pins_reg[2:1] != prev_pins_reg[2:1]) && button_testing_next)
            begin
                button_testing_next = 1'b0;
                if (plugged_next)
                begin
                    button_timer_next   = load_len(button_debounce_reg);
                    button_running_next = 1'b1;
                end
            end
            prev_pins_next = in_pins_reg;
        end

        // Result item.
        code = {tv_out_reg, mic_found_next, plugged_next};
        if (code == CODE_PLUG_ONLY)
        begin
            alt = ALT_PLUG_ONLY;
        end
        else if (code == CODE_PLUG_MIC)
        begin
            alt = ALT_PLUG_MIC;
        end
        else
        begin
            alt = code;
        end
        result = {bias_level_next, bevent, button_level_next, reported, alt, code};
    end

    // State update on each processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            main_timer_reg     <= '0;
            button_timer_reg   <= '0;
            plugged_reg        <= 1'b0;
            mic_found_reg      <= 1'b0;
            in_hold_reg        <= 1'b0;
            button_testing_reg <= 1'b0;
            button_level_reg   <= 1'b0;
            button_running_reg <= 1'b0;
            bias_level_reg     <= 1'b0;
            press_count_reg    <= '0;
            release_count_reg  <= '0;
            prev_pins_reg      <= 3'b001;
        end
        else if (fire)
        begin
            phase_reg          <= phase_next;
            main_timer_reg     <= main_timer_next;
            button_timer_reg   <= button_timer_next;
            plugged_reg        <= plugged_next;
            mic_found_reg      <= mic_found_next;
            in_hold_reg        <= in_hold_next;
            button_testing_reg <= button_testing_next;
            button_level_reg   <= button_level_next;
            button_running_reg <= button_running_next;
            bias_level_reg     <= bias_level_next;
            press_count_reg    <= press_count_next;
            release_count_reg  <= release_count_next;
            prev_pins_reg      <= prev_pins_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

endmodule

// ===== tb/sv/headset_jack_detector_tb.sv =====
module headset_jack_detector_tb;
    import hjd_pkg::*;

    localparam int CYCLE_LIMIT = 250000;

    // Result fields in the order of m_axis_tdata, lowest bits last.
    typedef struct packed {
        logic       mic_bias_on;
        logic       button_event;
        logic       button_down;
        logic       code_changed;
        logic [2:0] alt_code;
        logic [2:0] state_code;
    } jack_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;

    // Register copies kept by the predictor.
    logic [TICKS_W-1:0]   detect_db_len;
    logic [TICKS_W-1:0]   hold_len;
    logic [TICKS_W-1:0]   button_db_len;
    logic [TICKS_W-1:0]   settle_len;
    logic [REPEATS_W-1:0] repeat_limit;
    logic                 tv_out_flag;

    // Predicted jack and button state.
    logic [2:0]  seq_phase;
    logic [15:0] seq_timer;
    logic        is_plugged;
    logic        has_mic;
    logic        button_armed;
    logic        button_held;
    logic [7:0]  press_checks;
    logic [7:0]  release_checks;
    logic [15:0] check_timer;
    logic        check_running;
    logic [2:0]  last_pins;
    logic        bias_on;

    jack_report_t pending_reports[$];
    int           mismatch_count = 0;
    int           report_count = 0;
    int           cycle_count = 0;
    bit           src_idle_on = 1'b1;
    bit           sink_idle_on = 1'b1;

    headset_jack_detector dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports pending", cycle_count,
                     pending_reports.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Predictor.
    function automatic logic [15:0] timer_len(input logic [15:0] ticks);
        return (ticks == 16'd0) ? 16'd1 : ticks;
    endfunction

    function automatic logic timer_expired(inout logic [15:0] timer);
        if (timer <= 16'd1)
        begin
            timer = 16'd0;
            return 1'b1;
        end
        timer = timer - 16'd1;
        return 1'b0;
    endfunction

    function automatic void begin_settle(input logic [2:0] next_phase);
        bias_on = 1'b1;
        seq_phase = next_phase;
        seq_timer = timer_len(settle_len);
    endfunction

    function automatic void reset_predictor();
        detect_db_len = DETECT_DEBOUNCE_RST;
        hold_len = HOLD_RST;
        button_db_len = BUTTON_DEBOUNCE_RST;
        settle_len = BIAS_SETTLE_RST;
        repeat_limit = BUTTON_REPEATS_RST;
        tv_out_flag = 1'b0;
        seq_phase = PH_IDLE;
        seq_timer = '0;
        is_plugged = 1'b0;
        has_mic = 1'b0;
        button_armed = 1'b0;
        button_held = 1'b0;
        press_checks = '0;
        release_checks = '0;
        check_timer = '0;
        check_running = 1'b0;
        last_pins = 3'b001;
        bias_on = 1'b0;
    endfunction

    // One tick of the detector; pins are {send_end_b, send_end_a, detect_pin}.
    function automatic jack_report_t predict_tick(input logic [2:0] pins);
        logic         det;
        logic         sa;
        logic         sb;
        logic         mic_seen;
        logic         announced;
        logic         level_changed;
        logic         settled;
        logic         new_level;
        logic [2:0]   expired_phase;
        logic [2:0]   code;
        jack_report_t rpt;
        det = pins[0];
        sa = pins[1];
        sb = pins[2];
        mic_seen = sa && !sb;
        announced = 1'b0;
        level_changed = 1'b0;

        // Button check: equal send-ends count toward a press, unequal toward a release.
        if (check_running)
        begin
            if (timer_expired(check_timer))
            begin
                settled = 1'b0;
                new_level = 1'b0;
                check_running = 1'b0;
                if (det)
                begin
                    button_armed = 1'b0;
                    press_checks = '0;
                    release_checks = '0;
                end
                else if (sa == sb)
                begin
                    if (press_checks < repeat_limit)
                    begin
                        release_checks = '0;
                        press_checks = press_checks + 8'd1;
                        check_timer = timer_len(button_db_len);
                        check_running = 1'b1;
                    end
                    else
                    begin
                        settled = 1'b1;
                        new_level = 1'b1;
                    end
                end
                else
                begin
                    press_checks = '0;
                    if (release_checks < repeat_limit)
                    begin
                        release_checks = release_checks + 8'd1;
                        check_timer = timer_len(button_db_len);
                        check_running = 1'b1;
                    end
                    else
                    begin
                        settled = 1'b1;
                        new_level = 1'b0;
                    end
                end
                if (settled)
                begin
                    if (button_held != new_level)
                    begin
                        button_held = new_level;
                        level_changed = 1'b1;
                    end
                    press_checks = '0;
                    release_checks = '0;
                    button_armed = 1'b1;
                end
            end
        end

        // Detect, settle and hold sequencer.
        if (seq_phase != PH_IDLE)
        begin
            if (timer_expired(seq_timer))
            begin
                expired_phase = seq_phase;
                seq_phase = PH_IDLE;
                case (expired_phase)
                    PH_DEBOUNCE:
                    begin
                        button_armed = 1'b0;
                        if (!det != is_plugged)
                        begin
                            is_plugged = !det;
                            if (is_plugged)
                            begin
                                begin_settle(PH_SETTLE_PLUG);
                            end
                            else
                            begin
                                bias_on = 1'b0;
                                has_mic = 1'b0;
                                announced = 1'b1;
                            end
                        end
                        else if (is_plugged && has_mic)
                        begin
                            begin_settle(PH_SETTLE_RECHECK);
                        end
                        if (seq_phase == PH_IDLE)
                        begin
                            seq_phase = PH_HOLD;
                            seq_timer = timer_len(hold_len);
                        end
                    end
                    PH_SETTLE_PLUG, PH_SETTLE_RECHECK:
                    begin
                        if (!mic_seen)
                            bias_on = 1'b0;
                        if (expired_phase == PH_SETTLE_PLUG || has_mic != mic_seen)
                        begin
                            has_mic = mic_seen;
                            announced = 1'b1;
                        end
                        seq_phase = PH_HOLD;
                        seq_timer = timer_len(hold_len);
                    end
                    PH_HOLD:
                    begin
                        if (!has_mic)
                            begin_settle(PH_SETTLE_RETEST);
                        else
                            button_armed = 1'b1;
                    end
                    PH_SETTLE_RETEST:
                    begin
                        if (!mic_seen)
                            bias_on = 1'b0;
                        if (!has_mic && mic_seen)
                        begin
                            has_mic = 1'b1;
                            announced = 1'b1;
                        end
                        if (has_mic)
                            button_armed = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // Pin edges; the last pins stay frozen while a settle wait runs.
        if (seq_phase != PH_SETTLE_PLUG && seq_phase != PH_SETTLE_RECHECK &&
            seq_phase != PH_SETTLE_RETEST)
        begin
            if (pins[0] != last_pins[0])
            begin
                button_armed = 1'b0;
                seq_phase = PH_DEBOUNCE;
                seq_timer = timer_len(detect_db_len);
            end
            if (pins[2:1] != last_pins[2:1] && button_armed)
            begin
                button_armed = 1'b0;
                if (is_plugged)
                begin
                    check_timer = timer_len(button_db_len);
                    check_running = 1'b1;
                end
            end
            last_pins = pins;
        end

        code = {tv_out_flag, has_mic, is_plugged};
        rpt.state_code = code;
        if (code == CODE_PLUG_ONLY)
            rpt.alt_code = ALT_PLUG_ONLY;
        else if (code == CODE_PLUG_MIC)
            rpt.alt_code = ALT_PLUG_MIC;
        else
            rpt.alt_code = code;
        rpt.code_changed = announced;
        rpt.button_down = button_held;
        rpt.button_event = level_changed;
        rpt.mic_bias_on = bias_on;
        return rpt;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("ERROR report %0d field %s: got %0d, expected %0d", report_count, field,
                 got, want);
        mismatch_count++;
    endtask

    // Result checker.
    always @(posedge clk)
    begin : check_reports
        jack_report_t got;
        jack_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = jack_report_t'(m_axis_tdata[9:0]);
            if (pending_reports.size() == 0)
            begin
                report_mismatch("unexpected report", int'(m_axis_tdata), 0);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.state_code != want.state_code)
                    report_mismatch("state_code", int'(got.state_code),
                                    int'(want.state_code));
                if (got.alt_code != want.alt_code)
                    report_mismatch("alt_code", int'(got.alt_code), int'(want.alt_code));
                if (got.code_changed != want.code_changed)
                    report_mismatch("code_changed", int'(got.code_changed),
                                    int'(want.code_changed));
                if (got.button_down != want.button_down)
                    report_mismatch("button_down", int'(got.button_down),
                                    int'(want.button_down));
                if (got.button_event != want.button_event)
                    report_mismatch("button_event", int'(got.button_event),
                                    int'(want.button_event));
                if (got.mic_bias_on != want.mic_bias_on)
                    report_mismatch("mic_bias_on", int'(got.mic_bias_on),
                                    int'(want.mic_bias_on));
                if (m_axis_tdata[15:10] != 6'd0)
                    report_mismatch("padding", int'(m_axis_tdata[15:10]), 0);
            end
            report_count++;
        end
    end

    // Receiver with random stall bursts.
    initial
    begin : sink_stalls
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (sink_idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 16);
            m_axis_tready <= (stall_left == 0);
        end
    end

    // Register write while the block is idle; the predictor copy follows at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DETECT_DEBOUNCE: detect_db_len = val;
            REG_HOLD:            hold_len = val;
            REG_BUTTON_DEBOUNCE: button_db_len = val;
            REG_BIAS_SETTLE:     settle_len = val;
            REG_BUTTON_REPEATS:  repeat_limit = val[REPEATS_W-1:0];
            REG_TV_OUT:          tv_out_flag = val[0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic set_timing(input logic [15:0] detect_db, input logic [15:0] hold,
                              input logic [15:0] button_db, input logic [15:0] settle,
                              input logic [15:0] repeats, input logic [15:0] tv_out);
        write_reg(REG_DETECT_DEBOUNCE, detect_db);
        write_reg(REG_HOLD, hold);
        write_reg(REG_BUTTON_DEBOUNCE, button_db);
        write_reg(REG_BIAS_SETTLE, settle);
        write_reg(REG_BUTTON_REPEATS, repeats);
        write_reg(REG_TV_OUT, tv_out);
    endtask

    // Send one item of pins {send_end_b, send_end_a, detect_pin}.
    task automatic send_pins(input logic [2:0] pins);
        if (src_idle_on && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, pins};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_reports.push_back(predict_tick(pins));
    endtask

    task automatic send_run(input logic [2:0] pins, input int count);
        repeat (count) send_pins(pins);
    endtask

    // Hold off the sender until every predicted report has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // Reset register values: the long debounce only starts on a detect edge.
    task automatic test_reset_defaults();
        send_run(3'b001, 3);
        send_run(3'b010, 5);
        send_run(3'b001, 2);
        repeat (10) send_pins(3'($urandom_range(0, 7)));
    endtask

    // Largest timer lengths and repeat count; no timer runs out here.
    task automatic test_long_timers();
        wait_drained();
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (20) send_pins(3'($urandom_range(0, 7)));
        send_run(3'b000, 4);
        send_run(3'b111, 4);
        send_run(3'b001, 2);
    endtask

    // Short scripted plug, settle, hold and button sequence.
    task automatic test_directed();
        logic [2:0] script[] = '{
            3'b010, 3'b010,          // insert with mic pins, debounce runs out
            3'b110, 3'b010,          // send-end edge held during the settle wait
            3'b000,                  // button edge during hold is ignored
            3'b010,                  // hold ends, test arms, edge starts a check
            3'b000, 3'b000,          // press confirmed
            3'b010, 3'b010, 3'b010,  // release confirmed
            3'b000,                  // press check started
            3'b001, 3'b001,          // plug pulled during the check
            3'b001, 3'b001,          // hold ends unplugged, probe still runs
            3'b011, 3'b011,          // probe finds a mic while unplugged
            3'b001,                  // button edge while unplugged
            3'b000, 3'b001, 3'b000,  // detect edges restart the debounce
            3'b111, 3'b101, 3'b100
        };
        wait_drained();
        set_timing(16'd1, 16'd2, 16'd1, 16'd2, 16'd1, 16'd0);
        foreach (script[i])
            send_pins(script[i]);
    endtask

    // The tv-out flag shows in the state code without a report.
    task automatic test_tv_out();
        wait_drained();
        write_reg(REG_TV_OUT, 16'hFFFE);
        send_run(3'b100, 2);
        wait_drained();
        write_reg(REG_TV_OUT, 16'h0001);
        send_run(3'b010, 3);
        send_run(3'b001, 2);
    endtask

    // Press and release that need the largest repeat count.
    task automatic test_button_repeat_limit();
        wait_drained();
        set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'h00FF, 16'd0);
        send_run(3'b001, 3);
        send_run(3'b010, 12);
        send_run(3'b000, 262);
        send_run(3'b010, 262);
        send_run(3'b001, 8);
    endtask

    // One plug, some presses and an optional unplug, with lengths from the registers.
    task automatic play_session();
        int         dbn;
        int         hld;
        int         btn;
        int         stl;
        int         confirm_len;
        logic [2:0] plug_pins;
        logic [1:0] ends;
        dbn = int'(timer_len(detect_db_len));
        hld = int'(timer_len(hold_len));
        btn = int'(timer_len(button_db_len));
        stl = int'(timer_len(settle_len));
        confirm_len = (int'(repeat_limit) + 2) * btn;
        if ($urandom_range(0, 3) != 0)
        begin
            plug_pins = 3'b010;
        end
        else
        begin
            ends = 2'($urandom_range(0, 2));
            plug_pins = {ends[1] | ends[0], ends[1], 1'b0};
        end
        // Contact bounce on insertion now and then.
        if ($urandom_range(0, 3) == 0)
        begin
            send_run(plug_pins, $urandom_range(1, dbn));
            ends = 2'($urandom_range(0, 3));
            send_run({ends, 1'b1}, $urandom_range(1, 2));
        end
        send_run(plug_pins, dbn + stl + hld + stl + $urandom_range(1, 4));
        repeat ($urandom_range(0, 4))
        begin
            send_run($urandom_range(0, 1) ? 3'b000 : 3'b110,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * btn)
                                                 : confirm_len + $urandom_range(0, 3));
            send_run($urandom_range(0, 1) ? 3'b010 : 3'b100,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * btn)
                                                 : confirm_len + $urandom_range(0, 3));
        end
        if ($urandom_range(0, 2) != 0)
        begin
            ends = 2'($urandom_range(0, 3));
            send_run({ends, 1'b1}, dbn + hld + 2 * stl + $urandom_range(1, 4));
        end
    endtask

    // Random register setting, then mostly well-formed sessions with some noise.
    task automatic test_random_sessions(input int count, input bit idling);
        int sent_before;
        wait_drained();
        src_idle_on = idling;
        sink_idle_on = idling;
        set_timing(16'($urandom_range(0, 6)), 16'($urandom_range(1, 12)),
                   16'($urandom_range(0, 4)), 16'($urandom_range(1, 5)),
                   {8'($urandom_range(0, 255)), 8'($urandom_range(0, 4))},
                   16'($urandom_range(0, 65535)));
        sent_before = report_count + pending_reports.size();
        while (report_count + pending_reports.size() - sent_before < count)
        begin
            src_idle_on = idling && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) != 0)
                play_session();
            else
                repeat ($urandom_range(1, 12)) send_pins(3'($urandom_range(0, 7)));
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        reset_predictor();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_long_timers();
        test_directed();
        test_tv_out();
        test_button_repeat_limit();
        for (int n = 0; n < 5; n++)
            test_random_sessions(220, n < 4);
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
